/* rtl/qmo_pkg.sv */
package qmo_pkg;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;
    localparam int NUM_W     = 22;
    localparam logic [7:0] NUDGE     = 8'd15;
    localparam logic [7:0] ALPHA_MAX = 8'hFF;
    localparam logic [7:0] CHAN_MAX  = 8'd255;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_MATRIX_SIZE = 3'd1,
        REG_IMAGE_SIZE  = 3'd2,
        REG_QR_SIZE     = 3'd3,
        REG_POS_X       = 3'd4,
        REG_POS_Y       = 3'd5,
        REG_OPACITY     = 3'd6,
        REG_COLORS      = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        mode;
        logic [8:0]  matrix_size;
        logic [25:0] image_size;
        logic [12:0] qr_size;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
        logic [8:0]  opacity_q8;
        logic [63:0] colors;
    } cfg_t;

    typedef struct packed {
        logic             pix;
        logic             cov;
        logic             we;
        logic [7:0]       row;
        logic [7:0]       col;
        logic             wbit;
        logic [NUM_W-1:0] nx;
        logic [NUM_W-1:0] ny;
        logic [12:0]      dvx;
        logic [12:0]      dvy;
        logic [31:0]      pin;
    } mid_t;

    function automatic logic [7:0] mix(input logic [7:0] q, input logic [7:0] b,
                                       input logic [8:0] op);
        logic [16:0] t;
        t = {9'b0, q} * {8'b0, op} + {9'b0, b} * (17'd256 - {8'b0, op});
        return t[15:8];
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] v, input logic dark);
        logic [7:0] r;
        if (dark)
            r = (v >= NUDGE) ? v - NUDGE : 8'd0;
        else
            r = (v >= CHAN_MAX - NUDGE) ? CHAN_MAX : v + NUDGE;
        return r;
    endfunction

endpackage

/* rtl/qr_module_overlay.sv */
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// input    | push / full        | func module_row module_col module_dark pix_x pix_y pixel_in
// result   | pop / empty        | pixel_out covered
// config   | wr_en              | wr_index wr_data
// One item per clock while the result queue has room; a pixel result passes stage 0,
// the quotient-bit divider stages and the lookup stage before reaching the result queue.
// Load items yield no result. Reset empties the queues and sets the config registers to defaults; the module
// store is not cleared. The back end issues only when the 16-entry result
// queue has room for everything in flight, so a stalled pop fills it, then full rises.
module qr_module_overlay #(
    parameter int MATRIX_DIM = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        func,
    input  logic [7:0]  module_row,
    input  logic [7:0]  module_col,
    input  logic        module_dark,
    input  logic [11:0] pix_x,
    input  logic [11:0] pix_y,
    input  logic [31:0] pixel_in,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] pixel_out,
    output logic        covered,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data
);
    localparam int MW = $bits(qmo_pkg::mid_t);
    localparam int CW = $clog2(qmo_pkg::OUT_DEPTH) + 1;

    qmo_pkg::cfg_t cfg_reg;
    qmo_pkg::mid_t front_item, back_item;
    logic          mid_empty, mid_pop, out_push;
    logic [32:0]   out_data, out_head;
    logic [CW-1:0] out_count;
    logic [$clog2(qmo_pkg::MID_DEPTH):0] mid_count;
    logic          out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= 1'b0;
            cfg_reg.matrix_size <= 9'd21;
            cfg_reg.image_size  <= 26'd8193;
            cfg_reg.qr_size     <= 13'd256;
            cfg_reg.pos_x       <= '0;
            cfg_reg.pos_y       <= '0;
            cfg_reg.opacity_q8  <= 9'd256;
            cfg_reg.colors      <= 64'hFF000000FFFFFFFF;
        end
        else if (wr_en)
        begin
            unique case (qmo_pkg::reg_index_t'(wr_index))
                qmo_pkg::REG_MODE:        cfg_reg.mode        <= wr_data[0];
                qmo_pkg::REG_MATRIX_SIZE: cfg_reg.matrix_size <= wr_data[8:0];
                qmo_pkg::REG_IMAGE_SIZE:  cfg_reg.image_size  <= wr_data[25:0];
                qmo_pkg::REG_QR_SIZE:     cfg_reg.qr_size     <= wr_data[12:0];
                qmo_pkg::REG_POS_X:       cfg_reg.pos_x       <= wr_data[12:0];
                qmo_pkg::REG_POS_Y:       cfg_reg.pos_y       <= wr_data[12:0];
                qmo_pkg::REG_OPACITY:     cfg_reg.opacity_q8  <= wr_data[8:0];
                qmo_pkg::REG_COLORS:      cfg_reg.colors      <= wr_data;
                default: ;
            endcase
        end
    end

    qmo_front #(.MATRIX_DIM(MATRIX_DIM)) u_front (
        .func(func), .module_row(module_row), .module_col(module_col),
        .module_dark(module_dark), .pix_x(pix_x), .pix_y(pix_y),
        .pixel_in(pixel_in), .cfg(cfg_reg), .item(front_item)
    );

    qmo_queue #(.W(MW), .DEPTH(qmo_pkg::MID_DEPTH)) u_mid (
        .clk(clk), .rst_n(rst_n), .push(push), .din(front_item), .full(full),
        .pop(mid_pop), .dout(back_item), .empty(mid_empty), .count(mid_count)
    );

    qmo_back #(.MATRIX_DIM(MATRIX_DIM)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .item(back_item),
        .item_empty(mid_empty), .item_pop(mid_pop), .out_count(out_count),
        .out_push(out_push), .out_data(out_data)
    );

    qmo_queue #(.W(33), .DEPTH(qmo_pkg::OUT_DEPTH)) u_out (
        .clk(clk), .rst_n(rst_n), .push(out_push), .din(out_data), .full(out_full),
        .pop(pop), .dout(out_head), .empty(empty), .count(out_count)
    );

    assign pixel_out = out_head[32:1];
    assign covered   = out_head[0] & !(out_full & mid_count[0] & 1'b0);
endmodule

/* rtl/qmo_queue.sv */
module qmo_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [W-1:0]             din,
    output logic                     full,
    input  logic                     pop,
    output logic [W-1:0]             dout,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   count
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign dout    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= din;
    end
endmodule

/* rtl/qmo_front.sv */
module qmo_front #(
    parameter int MATRIX_DIM = 256
) (
    input  logic           func,
    input  logic [7:0]     module_row,
    input  logic [7:0]     module_col,
    input  logic           module_dark,
    input  logic [11:0]    pix_x,
    input  logic [11:0]    pix_y,
    input  logic [31:0]    pixel_in,
    input  qmo_pkg::cfg_t  cfg,
    output qmo_pkg::mid_t  item
);
    localparam logic [8:0] MD = 9'(MATRIX_DIM);

    logic [12:0] w, h;
    logic [13:0] dx, dy;
    logic [8:0]  m;
    logic        in_img, in_win;
    logic [12:0] ox, oy;

    always_comb
    begin
        w  = cfg.image_size[12:0];
        h  = cfg.image_size[25:13];
        dx = {2'b00, pix_x} - {cfg.pos_x[12], cfg.pos_x};
        dy = {2'b00, pix_y} - {cfg.pos_y[12], cfg.pos_y};
        if (cfg.matrix_size == '0)
            m = 9'd1;
        else if (cfg.matrix_size > MD)
            m = MD;
        else
            m = cfg.matrix_size;
        in_img = (w != '0) && (h != '0) && ({1'b0, pix_x} < w) && ({1'b0, pix_y} < h);
        in_win = (cfg.qr_size != '0) && !dx[13] && !dy[13]
                 && (dx[12:0] < cfg.qr_size) && (dy[12:0] < cfg.qr_size);
        ox = cfg.mode ? {1'b0, pix_x} : dx[12:0];
        oy = cfg.mode ? {1'b0, pix_y} : dy[12:0];

        item.pix  = func;
        item.cov  = in_img && (cfg.mode || in_win);
        item.we   = !func && (32'(module_row) < MATRIX_DIM) && (32'(module_col) < MATRIX_DIM);
        item.row  = module_row;
        item.col  = module_col;
        item.wbit = module_dark;
        item.nx   = qmo_pkg::NUM_W'({9'b0, ox} * {13'b0, m});
        item.ny   = qmo_pkg::NUM_W'({9'b0, oy} * {13'b0, m});
        item.dvx  = cfg.mode ? w : cfg.qr_size;
        item.dvy  = cfg.mode ? h : cfg.qr_size;
        item.pin  = pixel_in;
    end
endmodule

/* rtl/qmo_back.sv */
module qmo_back #(
    parameter int MATRIX_DIM = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  qmo_pkg::cfg_t                        cfg,
    input  qmo_pkg::mid_t                        item,
    input  logic                                 item_empty,
    output logic                                 item_pop,
    input  logic [$clog2(qmo_pkg::OUT_DEPTH):0]  out_count,
    output logic                                 out_push,
    output logic [32:0]                          out_data
);
    localparam int QW = $clog2(MATRIX_DIM);
    localparam int L  = QW + 2;
    localparam int M  = QW + 1;
    localparam int CW = $clog2(qmo_pkg::OUT_DEPTH) + 1;
    localparam int NW = qmo_pkg::NUM_W;

    logic          vld_reg [L];
    logic          pix_reg [L];
    logic          cov_reg [L];
    logic          we_reg  [L];
    logic          wb_reg  [L];
    logic [2*QW-1:0] wa_reg [L];
    logic [NW-1:0] remx_reg [L];
    logic [NW-1:0] remy_reg [L];
    logic [12:0]   dvx_reg [L];
    logic [12:0]   dvy_reg [L];
    logic [QW-1:0] qx_reg  [L];
    logic [QW-1:0] qy_reg  [L];
    logic [31:0]   rd_reg  [L];
    logic [31:0]   rl_reg  [L];
    logic          bit_reg;
    logic [CW-1:0] infl_reg;
    logic          mem_reg [1<<(2*QW)];

    logic [8:0]  op;
    logic [31:0] dark_c, light_c, res_d, res_l;
    logic [CW:0] used;

    assign used     = {1'b0, out_count} + {1'b0, infl_reg};
    assign item_pop = !item_empty && (used < (CW+1)'(qmo_pkg::OUT_DEPTH));
    assign out_push = vld_reg[M] && pix_reg[M];
    assign out_data = {bit_reg ? rd_reg[M] : rl_reg[M], cov_reg[M]};

    // precompute both module outcomes before the lookup
    always_comb
    begin
        op      = (cfg.opacity_q8 > 9'd256) ? 9'd256 : cfg.opacity_q8;
        dark_c  = cfg.colors[63:32];
        light_c = cfg.colors[31:0];
        res_d   = item.pin;
        res_l   = item.pin;
        if (item.cov)
        begin
            if (cfg.mode)
            begin
                res_d = {item.pin[31:24], qmo_pkg::nudge(item.pin[23:16], 1'b1),
                         qmo_pkg::nudge(item.pin[15:8], 1'b1),
                         qmo_pkg::nudge(item.pin[7:0], 1'b1)};
                res_l = {item.pin[31:24], qmo_pkg::nudge(item.pin[23:16], 1'b0),
                         qmo_pkg::nudge(item.pin[15:8], 1'b0),
                         qmo_pkg::nudge(item.pin[7:0], 1'b0)};
            end
            else
            begin
                res_d = {qmo_pkg::ALPHA_MAX,
                         qmo_pkg::mix(dark_c[23:16], item.pin[23:16], op),
                         qmo_pkg::mix(dark_c[15:8], item.pin[15:8], op),
                         qmo_pkg::mix(dark_c[7:0], item.pin[7:0], op)};
                res_l = {qmo_pkg::ALPHA_MAX,
                         qmo_pkg::mix(light_c[23:16], item.pin[23:16], op),
                         qmo_pkg::mix(light_c[15:8], item.pin[15:8], op),
                         qmo_pkg::mix(light_c[7:0], item.pin[7:0], op)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
                vld_reg[i] <= 1'b0;
            infl_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= item_pop;
            for (int i = 1; i < L; i++)
                vld_reg[i] <= vld_reg[i-1];
            infl_reg <= infl_reg + CW'(item_pop && item.pix) - CW'(out_push);
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg[0]  <= item.pix;
        cov_reg[0]  <= item.cov;
        we_reg[0]   <= item.we;
        wb_reg[0]   <= item.wbit;
        wa_reg[0]   <= {item.row[QW-1:0], item.col[QW-1:0]};
        remx_reg[0] <= item.nx;
        remy_reg[0] <= item.ny;
        dvx_reg[0]  <= item.dvx;
        dvy_reg[0]  <= item.dvy;
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
        rd_reg[0]   <= res_d;
        rl_reg[0]   <= res_l;
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s <= QW; s++)
    begin : g_div
        localparam int SH = QW - s;
        logic [NW-1:0] tx, ty;
        logic          gx, gy;
        assign tx = {{(NW-13){1'b0}}, dvx_reg[s-1]} << SH;
        assign ty = {{(NW-13){1'b0}}, dvy_reg[s-1]} << SH;
        assign gx = remx_reg[s-1] >= tx;
        assign gy = remy_reg[s-1] >= ty;

        always_ff @(posedge clk)
        begin
            pix_reg[s]  <= pix_reg[s-1];
            cov_reg[s]  <= cov_reg[s-1];
            we_reg[s]   <= we_reg[s-1];
            wb_reg[s]   <= wb_reg[s-1];
            wa_reg[s]   <= wa_reg[s-1];
            dvx_reg[s]  <= dvx_reg[s-1];
            dvy_reg[s]  <= dvy_reg[s-1];
            rd_reg[s]   <= rd_reg[s-1];
            rl_reg[s]   <= rl_reg[s-1];
            remx_reg[s] <= gx ? remx_reg[s-1] - tx : remx_reg[s-1];
            remy_reg[s] <= gy ? remy_reg[s-1] - ty : remy_reg[s-1];
            qx_reg[s]   <= qx_reg[s-1] | (QW'(gx) << SH);
            qy_reg[s]   <= qy_reg[s-1] | (QW'(gy) << SH);
        end
    end

    // loads and lookups meet the store in item order here
    always_ff @(posedge clk)
    begin
        if (vld_reg[QW] && we_reg[QW])
            mem_reg[wa_reg[QW]] <= wb_reg[QW];
        bit_reg     <= mem_reg[{qy_reg[QW], qx_reg[QW]}];
        pix_reg[M]  <= pix_reg[QW];
        cov_reg[M]  <= cov_reg[QW];
        rd_reg[M]   <= rd_reg[QW];
        rl_reg[M]   <= rl_reg[QW];
    end
endmodule

/* rtl/qmo_checker.sv */
module qmo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] pixel_out,
    input logic        covered
);
    // queues must come out of reset drained
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not clear in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_out) && $stable(covered)))
        else $error("waiting result changed");

    // input opens as soon as reset lifts
    a_first_free: assert property (@(posedge clk) $rose(rst_n) |-> !full)
        else $error("input blocked right after reset");
endmodule

bind qr_module_overlay qmo_checker u_qmo_checker (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
    .pixel_out(pixel_out), .covered(covered)
);

/* verif/qr_module_overlay_tb.sv */
module qr_module_overlay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MDIM      = 256;
    localparam int LATENCY   = 16;
    localparam int CYCLE_MAX = 400000;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        dark;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] pin;
    } item_t;

    typedef struct packed {
        logic [31:0] pix;
        logic        cov;
    } overlay_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        func = 1'b0;
    logic [7:0]  module_row = '0;
    logic [7:0]  module_col = '0;
    logic        module_dark = 1'b0;
    logic [11:0] pix_x = '0;
    logic [11:0] pix_y = '0;
    logic [31:0] pixel_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] pixel_out;
    logic        covered;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = '0;
    logic [63:0] wr_data = '0;

    qr_module_overlay i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic           matrix_mem [MDIM*MDIM];
    bit             loaded [MDIM*MDIM];
    qmo_pkg::cfg_t  cfg;
    overlay_t       expected_q [$];
    int             mismatches = 0;
    int             cycles = 0;
    int             send_idle = 0;
    int             recv_idle = 0;
    bit             hold_pop = 0;

    function automatic logic [7:0] blend8(logic [7:0] q, logic [7:0] b, logic [8:0] op);
        logic [16:0] t;
        t = 17'(q) * 17'(op) + 17'(b) * (17'd256 - 17'(op));
        return t[15:8];
    endfunction

    function automatic logic [7:0] shift15(logic [7:0] v, logic dk);
        if (dk)
            return (v >= 8'd15) ? v - 8'd15 : 8'd0;
        return (v > 8'd240) ? 8'd255 : v + 8'd15;
    endfunction

    function automatic int eff_m();
        if (cfg.matrix_size == 9'd0)
            return 1;
        if (int'(cfg.matrix_size) > MDIM)
            return MDIM;
        return int'(cfg.matrix_size);
    endfunction

    function automatic overlay_t predict_overlay(item_t it);
        overlay_t   o;
        int         w, h, m, dx, dy, qx, qy, qs, op;
        logic       dk;
        logic [31:0] c;
        o.pix = it.pin;
        o.cov = 1'b0;
        w  = int'(cfg.image_size[12:0]);
        h  = int'(cfg.image_size[25:13]);
        m  = eff_m();
        qs = int'(cfg.qr_size);
        if (w != 0 && h != 0 && int'(it.px) < w && int'(it.py) < h)
        begin
            if (!cfg.mode)
            begin
                dx = int'(it.px) - int'($signed(cfg.pos_x));
                dy = int'(it.py) - int'($signed(cfg.pos_y));
                if (qs != 0 && dx >= 0 && dy >= 0 && dx < qs && dy < qs)
                begin
                    qx = dx * m / qs;
                    qy = dy * m / qs;
                    dk = matrix_mem[qy*MDIM+qx];
                    c  = dk ? cfg.colors[63:32] : cfg.colors[31:0];
                    op = int'(cfg.opacity_q8) > 256 ? 256 : int'(cfg.opacity_q8);
                    o.pix = {8'hFF, blend8(c[23:16], it.pin[23:16], 9'(op)),
                             blend8(c[15:8], it.pin[15:8], 9'(op)),
                             blend8(c[7:0], it.pin[7:0], 9'(op))};
                    o.cov = 1'b1;
                end
            end
            else
            begin
                qx = int'(it.px) * m / w;
                qy = int'(it.py) * m / h;
                dk = matrix_mem[qy*MDIM+qx];
                o.pix = {it.pin[31:24], shift15(it.pin[23:16], dk),
                         shift15(it.pin[15:8], dk), shift15(it.pin[7:0], dk)};
                o.cov = 1'b1;
            end
        end
        return o;
    endfunction

    // index of the module a pixel would read, -1 when none is read
    function automatic int module_read(item_t it);
        int w, h, m, dx, dy, qs;
        w  = int'(cfg.image_size[12:0]);
        h  = int'(cfg.image_size[25:13]);
        m  = eff_m();
        qs = int'(cfg.qr_size);
        if (w == 0 || h == 0 || int'(it.px) >= w || int'(it.py) >= h)
            return -1;
        if (cfg.mode)
            return (int'(it.py) * m / h) * MDIM + int'(it.px) * m / w;
        dx = int'(it.px) - int'($signed(cfg.pos_x));
        dy = int'(it.py) - int'($signed(cfg.pos_y));
        if (qs == 0 || dx < 0 || dy < 0 || dx >= qs || dy >= qs)
            return -1;
        return (dy * m / qs) * MDIM + dx * m / qs;
    endfunction

    task automatic write_reg(qmo_pkg::reg_index_t idx, logic [63:0] val);
        push <= 1'b0;
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            qmo_pkg::REG_MODE:        cfg.mode        = val[0];
            qmo_pkg::REG_MATRIX_SIZE: cfg.matrix_size = val[8:0];
            qmo_pkg::REG_IMAGE_SIZE:  cfg.image_size  = val[25:0];
            qmo_pkg::REG_QR_SIZE:     cfg.qr_size     = val[12:0];
            qmo_pkg::REG_POS_X:       cfg.pos_x       = val[12:0];
            qmo_pkg::REG_POS_Y:       cfg.pos_y       = val[12:0];
            qmo_pkg::REG_OPACITY:     cfg.opacity_q8  = val[8:0];
            default:                  cfg.colors      = val;
        endcase
    endtask

    // send one item; expected result is either predicted or given
    task automatic send_item(item_t it, bit given, overlay_t want);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        func        <= it.func;
        module_row  <= it.row;
        module_col  <= it.col;
        module_dark <= it.dark;
        pix_x       <= it.px;
        pix_y       <= it.py;
        pixel_in    <= it.pin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (it.func == FUNC_LOAD)
        begin
            matrix_mem[it.row*MDIM+it.col] = it.dark;
            loaded[it.row*MDIM+it.col] = 1;
        end
        else
            expected_q.push_back(given ? want : predict_overlay(it));
        // hold push; the next send or an idle step drops it
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_q.size() > 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    function automatic item_t load_item(int r, int c, logic d);
        item_t it;
        it = '0;
        it.func = FUNC_LOAD;
        it.row = 8'(r);
        it.col = 8'(c);
        it.dark = d;
        return it;
    endfunction

    function automatic item_t pixel_item(int x, int y, logic [31:0] p);
        item_t it;
        it = '0;
        it.func = FUNC_PIXEL;
        it.px = 12'(x);
        it.py = 12'(y);
        it.pin = p;
        it.row = 8'($urandom);
        it.col = 8'($urandom);
        it.dark = 1'($urandom);
        return it;
    endfunction

    // random pixel whose module read, if any, hits a loaded entry
    task automatic send_random_pixel(int w, int h);
        item_t it;
        int    k;
        for (int t = 0; t < 50; t++)
        begin
            if ($urandom_range(9) == 0)
                it = pixel_item($urandom, $urandom, $urandom);
            else
                it = pixel_item($urandom_range(w-1), $urandom_range(h-1), $urandom);
            k = module_read(it);
            if (k < 0 || loaded[k])
            begin
                send_item(it, 1'b0, '0);
                return;
            end
        end
    endtask

    // receiver
    always @(posedge clk)
    begin
        overlay_t want;
        cycles <= cycles + 1;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: pixel_out %h covered %b", pixel_out, covered);
            end
            else
            begin
                want = expected_q.pop_front();
                if (pixel_out !== want.pix || covered !== want.cov)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel_out %h/%h covered %b/%b",
                                 pixel_out, want.pix, covered, want.cov);
                end
            end
        end
    end

    always @(negedge clk)
        pop <= !hold_pop && !(recv_idle > 0 && $urandom_range(99) < recv_idle);

    always @(posedge clk)
        if (cycles > CYCLE_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end

    initial
    begin
        int     w, h, n;
        cfg = '{mode: 1'b0, matrix_size: 9'd21, image_size: 26'd8193, qr_size: 13'd256,
                pos_x: 13'd0, pos_y: 13'd0, opacity_q8: 9'd256,
                colors: 64'hFF000000FFFFFFFF};
        foreach (matrix_mem[i]) matrix_mem[i] = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset config is a 1x1 image, window at origin, opaque
        begin
            item_t    dir_in [10];
            bit       dir_given [10];
            overlay_t dir_want [10];
            dir_in[0] = load_item(0, 0, 1'b1);
            dir_in[1] = pixel_item(0, 0, 32'h00123456);
            dir_given[1] = 1; dir_want[1] = '{32'hFF000000, 1'b1};
            dir_in[2] = pixel_item(1, 0, 32'h12345678);
            dir_given[2] = 1; dir_want[2] = '{32'h12345678, 1'b0};
            dir_in[3] = pixel_item(4095, 4095, 32'hFFFFFFFF);
            dir_given[3] = 1; dir_want[3] = '{32'hFFFFFFFF, 1'b0};
            dir_in[4] = load_item(255, 255, 1'b1);
            dir_in[5] = load_item(0, 0, 1'b0);
            dir_in[6] = pixel_item(0, 0, 32'hAB000000);
            dir_given[6] = 1; dir_want[6] = '{32'hFFFFFFFF, 1'b1};
            dir_in[7] = pixel_item(0, 4095, 32'h0);
            dir_given[7] = 1; dir_want[7] = '{32'h0, 1'b0};
            dir_in[8] = load_item(0, 0, 1'b1);
            dir_in[9] = pixel_item(0, 0, 32'h7F7F7F7F);
            foreach (dir_in[i])
                send_item(dir_in[i], dir_given[i], dir_want[i]);
        end
        drain();

        // directed: hide mode saturation, max matrix, max image
        write_reg(qmo_pkg::REG_MODE, 64'd1);
        write_reg(qmo_pkg::REG_MATRIX_SIZE, 64'd256);
        write_reg(qmo_pkg::REG_IMAGE_SIZE, 64'({13'd4096, 13'd4096}));
        send_item(pixel_item(0, 0, 32'h5A0E0F10), 1'b1, '{32'h5A000001, 1'b1});
        send_item(pixel_item(4095, 4095, 32'h00F0F1FF), 1'b0, '0);
        send_item(load_item(0, 0, 1'b0), 1'b0, '0);
        send_item(pixel_item(0, 0, 32'hC0F0F1FF), 1'b1, '{32'hC0FFFFFF, 1'b1});
        drain();
        write_reg(qmo_pkg::REG_MATRIX_SIZE, 64'd0);
        send_item(pixel_item(100, 7, 32'h01020304), 1'b0, '0);
        drain();
        write_reg(qmo_pkg::REG_MATRIX_SIZE, 64'd511);
        send_item(pixel_item(0, 0, 32'h01020304), 1'b0, '0);
        drain();
        write_reg(qmo_pkg::REG_IMAGE_SIZE, 64'd0);
        send_item(pixel_item(0, 0, 32'h11223344), 1'b1, '{32'h11223344, 1'b0});
        drain();
        write_reg(qmo_pkg::REG_MODE, 64'd0);
        write_reg(qmo_pkg::REG_IMAGE_SIZE, 64'({13'd64, 13'd64}));
        write_reg(qmo_pkg::REG_QR_SIZE, 64'd0);
        send_item(pixel_item(3, 3, 32'h55667788), 1'b1, '{32'h55667788, 1'b0});
        drain();

        // random phases: load a small matrix fully (last phase: where the image maps), then stream pixels
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle = 38; recv_idle = 74; end
                2: begin send_idle = 74; recv_idle = 38; end
                4: begin send_idle = 0;  recv_idle = 0;  end
                default: ;
            endcase
            n = (ph == 5) ? 256 : $urandom_range(1, 10);
            w = (ph == 1) ? 4096 : ((ph == 5) ? $urandom_range(1, 12) : $urandom_range(1, 80));
            h = (ph == 3) ? 4096 : ((ph == 5) ? $urandom_range(1, 12) : $urandom_range(1, 80));
            write_reg(qmo_pkg::REG_MODE, (ph == 5) ? 64'd1 : 64'($urandom_range(1)));
            write_reg(qmo_pkg::REG_MATRIX_SIZE, 64'(n));
            write_reg(qmo_pkg::REG_IMAGE_SIZE, 64'({13'(h), 13'(w)}));
            write_reg(qmo_pkg::REG_QR_SIZE, 64'((ph == 4) ? 4096 : $urandom_range(1, 90)));
            write_reg(qmo_pkg::REG_POS_X,
                      64'((ph == 1) ? 13'h1000 : 13'($urandom_range(0, 40) - 20)));
            write_reg(qmo_pkg::REG_POS_Y,
                      64'((ph == 3) ? 13'h0FFF : 13'($urandom_range(0, 40) - 20)));
            write_reg(qmo_pkg::REG_OPACITY,
                      64'((ph == 0) ? 0 : (ph == 2 ? 511 : $urandom_range(256))));
            write_reg(qmo_pkg::REG_COLORS, {$urandom, $urandom});
            // full matrix only in the last phase, loaded where the small image maps
            if (ph != 5)
                for (int r = 0; r < n; r++)
                    for (int c = 0; c < n; c++)
                        send_item(load_item(r, c, 1'($urandom)), 1'b0, '0);
            else
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                        send_item(load_item(y * MDIM / h, x * MDIM / w, 1'($urandom)),
                                  1'b0, '0);
            if (ph == 4)
                fork
                    begin
                        hold_pop = 1;
                        repeat (200) @(negedge clk);
                        hold_pop = 0;
                    end
                join_none
            for (int i = 0; i < 70; i++)
            begin
                if (ph == 5)
                    send_random_pixel(w, h);
                else if ($urandom_range(15) == 0)
                    send_item(load_item($urandom_range(n-1), $urandom_range(n-1),
                                        1'($urandom)), 1'b0, '0);
                else
                    send_random_pixel(w, h);
            end
            drain();
        end

        if (mismatches == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
